@@ hdl/bnc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types, codes and decode functions of the bracket nesting checker.
// ----------------------------------------------------------------------------
package bnc_pkg;

  localparam int DEFAULT_STACK_DEPTH = 128;
  localparam int CHAR_W              = 8;
  localparam int STATUS_W            = 3;
  localparam int SCORE_W             = 64;
  localparam int KIND_W              = 2;

  localparam logic [CHAR_W-1:0] CH_OPEN_PAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_OPEN_CURLY  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_OPEN_ANGLE  = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_CLOSE_PAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_CLOSE_ANGLE  = 8'h3E;

  localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_BALANCED   = 3'd0,
    ST_INCOMPLETE = 3'd1,
    ST_MISMATCH   = 3'd2,
    ST_UNDERFLOW  = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_UNWIND,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } kind_dec_t;

  function automatic kind_dec_t decode_open(input logic [CHAR_W-1:0] c);
    kind_dec_t d;
    d.hit  = 1'b1;
    d.kind = KIND_PAREN;
    unique case (c)
      CH_OPEN_PAREN:  d.kind = KIND_PAREN;
      CH_OPEN_SQUARE: d.kind = KIND_SQUARE;
      CH_OPEN_CURLY:  d.kind = KIND_CURLY;
      CH_OPEN_ANGLE:  d.kind = KIND_ANGLE;
      default:        d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  function automatic kind_dec_t decode_close(input logic [CHAR_W-1:0] c);
    kind_dec_t d;
    d.hit  = 1'b1;
    d.kind = KIND_PAREN;
    unique case (c)
      CH_CLOSE_PAREN:  d.kind = KIND_PAREN;
      CH_CLOSE_SQUARE: d.kind = KIND_SQUARE;
      CH_CLOSE_CURLY:  d.kind = KIND_CURLY;
      CH_CLOSE_ANGLE:  d.kind = KIND_ANGLE;
      default:         d.hit  = 1'b0;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/bracket_nesting_checker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_nesting_checker_top
// Checks bracket nesting of a line, one character per request.
// ----------------------------------------------------------------------------
// Input channel (in_*): one character per request, in_end_of_line marks the
// last character of a line. in_stall is high while a character is in work.
// Output channel (out_*): one request per line, given after the marked
// character: line status and, for an incomplete line, its completion score.
// Each character is accepted, then the stack is updated with the top entry
// read from the stack memory the cycle before. A final character then places
// the result; for an incomplete line a load step and one unwind step per open
// entry come first, as one shared 64-bit multiply-by-5-and-add unit builds
// the score while it walks the stack from the top, one memory read per cycle.
// The result sits in an output register; new characters are accepted while
// it waits. If the receiver stalls and a second result is ready, the block
// holds it and stalls its input until the output register frees.
// Reset (rst_n low, synchronous) empties the stack and clears error and
// output valid; stack contents need no clearing.
// ----------------------------------------------------------------------------
module bracket_nesting_checker_top #(
  parameter int STACK_DEPTH = bnc_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bnc_pkg::CHAR_W-1:0]    in_char_code,
  input  logic                          in_end_of_line,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bnc_pkg::STATUS_W-1:0]  out_line_status,
  output logic [bnc_pkg::SCORE_W-1:0]   out_completion_score
);
  import bnc_pkg::*;

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  state_t               state_r, state_nxt;
  logic [CHAR_W-1:0]    char_r;
  logic                 eol_r;
  logic [LW-1:0]        level_r, level_nxt;
  status_t              err_r, err_nxt;
  status_t              status_r, status_nxt;
  logic [SCORE_W-1:0]   score_r, score_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r;
  logic [SCORE_W-1:0]   out_score_r;

  logic                 in_take;
  logic                 out_free;
  kind_dec_t            od, cd;
  logic [LW-1:0]        ex_level;
  status_t              ex_err;
  logic                 ex_push;
  logic [LW-1:0]        lvl_m1, lvl_m2;
  logic [IW-1:0]        raddr;
  logic [KIND_W-1:0]    rd_kind;
  logic [SCORE_W-1:0]   mac;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign od = decode_open(char_r);
  assign cd = decode_close(char_r);

  assign lvl_m1 = level_r - LW'(1);
  assign lvl_m2 = level_r - LW'(2);
  assign raddr  = (state_r == S_UNWIND) ? lvl_m2[IW-1:0] : lvl_m1[IW-1:0];

  bnc_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .IW          (IW)
  ) u_stack (
    .clk   (clk),
    .we    (ex_push && (state_r == S_EXEC)),
    .waddr (level_r[IW-1:0]),
    .wdata (od.kind),
    .raddr (raddr),
    .rdata (rd_kind)
  );

  // shared unit: score*5 + kind + 1
  assign mac = (score_r << 2) + score_r + SCORE_W'(rd_kind) + SCORE_W'(1);

  always_comb begin
    ex_level = level_r;
    ex_err   = err_r;
    ex_push  = 1'b0;
    if (err_r == ST_BALANCED) begin
      if (od.hit) begin
        if (level_r == LW'(STACK_DEPTH)) begin
          ex_err = ST_OVERFLOW;
        end else begin
          ex_push  = 1'b1;
          ex_level = level_r + LW'(1);
        end
      end else if (cd.hit) begin
        if (level_r == '0) begin
          ex_err = ST_UNDERFLOW;
        end else begin
          ex_level = lvl_m1;
          if (rd_kind != cd.kind) begin
            ex_err = ST_MISMATCH;
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!eol_r) begin
          state_nxt = S_IDLE;
        end else if (ex_err == ST_BALANCED && ex_level != '0) begin
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_LOAD: state_nxt = S_UNWIND;
      S_UNWIND: begin
        if (level_r == LW'(1)) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    level_nxt     = level_r;
    err_nxt       = err_r;
    status_nxt    = status_r;
    score_nxt     = score_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: ;
      S_EXEC: begin
        level_nxt = ex_level;
        err_nxt   = ex_err;
        if (eol_r) begin
          score_nxt = '0;
          if (ex_err != ST_BALANCED) begin
            status_nxt = ex_err;
          end else if (ex_level == '0) begin
            status_nxt = ST_BALANCED;
          end else begin
            status_nxt = ST_INCOMPLETE;
          end
        end
      end
      S_LOAD: ;
      S_UNWIND: begin
        score_nxt = mac;
        level_nxt = lvl_m1;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          level_nxt     = '0;
          err_nxt       = ST_BALANCED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      err_r       <= ST_BALANCED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_r <= in_char_code;
      eol_r  <= in_end_of_line;
    end
    status_r <= status_nxt;
    score_r  <= score_nxt;
    if (state_r == S_EMIT && out_free) begin
      out_status_r <= status_r;
      out_score_r  <= score_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_line_status      = out_status_r;
  assign out_completion_score = out_score_r;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit");

  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> (level_r == '0 && err_r == ST_BALANCED))
    else $error("line state not cleared after result");

  a_unwind_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNWIND) |-> (status_r == ST_INCOMPLETE && level_r != '0))
    else $error("unwind without open entries");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r == ST_BALANCED || err_r == ST_MISMATCH ||
     err_r == ST_UNDERFLOW || err_r == ST_OVERFLOW))
    else $error("bad line error code");

endmodule

@@ hdl/bnc_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_stack
// Bracket kind store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bnc_stack #(
  parameter int STACK_DEPTH = bnc_pkg::DEFAULT_STACK_DEPTH,
  parameter int IW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [IW-1:0]               waddr,
  input  logic [bnc_pkg::KIND_W-1:0]  wdata,
  input  logic [IW-1:0]               raddr,
  output logic [bnc_pkg::KIND_W-1:0]  rdata
);
  import bnc_pkg::*;

  logic [KIND_W-1:0] mem [STACK_DEPTH];
  logic [KIND_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks bracket_nesting_checker_top one character request at a time.
// Lines are built from bracket-aware generators (balanced, left open, broken,
// noise, and deep lines that fill or overflow the stack) and driven with
// random gaps. A scoreboard tracks the open-bracket stack per line and
// compares each line result, status and completion score, in order.
// ----------------------------------------------------------------------------
module testbench;
  import bnc_pkg::*;

  localparam int DEPTH     = DEFAULT_STACK_DEPTH;
  localparam int N_ITEMS   = 1400;
  localparam int LIMIT     = 1500000;
  localparam int HOLD_LONG = 500;

  localparam int LM_BALANCED      = 0;
  localparam int LM_OPEN          = 1;
  localparam int LM_BROKEN        = 2;
  localparam int LM_NOISE         = 3;
  localparam int LM_OVERFLOW      = 4;
  localparam int LM_FULL_OPEN     = 5;
  localparam int LM_FULL_BALANCED = 6;

  typedef struct packed {
    status_t            status;
    logic [SCORE_W-1:0] score;
  } line_result_t;

  class nesting_scoreboard;
    logic [KIND_W-1:0] kinds [DEPTH];
    int unsigned       depth;
    status_t           err;
    line_result_t      lines_due [$];
    int unsigned       errors;
    int unsigned       results;

    function new();
      depth   = 0;
      err     = ST_BALANCED;
      errors  = 0;
      results = 0;
    endfunction

    function void note_request(logic [CHAR_W-1:0] c, logic eol);
      logic              is_open;
      logic              is_close;
      logic [KIND_W-1:0] k;
      line_result_t      r;
      is_open  = 1'b0;
      is_close = 1'b0;
      k        = KIND_PAREN;
      case (c)
        CH_OPEN_PAREN: begin is_open = 1'b1; k = KIND_PAREN; end
        CH_OPEN_SQUARE: begin is_open = 1'b1; k = KIND_SQUARE; end
        CH_OPEN_CURLY: begin is_open = 1'b1; k = KIND_CURLY; end
        CH_OPEN_ANGLE: begin is_open = 1'b1; k = KIND_ANGLE; end
        CH_CLOSE_PAREN: begin is_close = 1'b1; k = KIND_PAREN; end
        CH_CLOSE_SQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
        CH_CLOSE_CURLY: begin is_close = 1'b1; k = KIND_CURLY; end
        CH_CLOSE_ANGLE: begin is_close = 1'b1; k = KIND_ANGLE; end
        default: begin end
      endcase
      if (err == ST_BALANCED) begin
        if (is_open) begin
          if (depth >= DEPTH) begin
            err = ST_OVERFLOW;
          end else begin
            kinds[depth] = k;
            depth++;
          end
        end else if (is_close) begin
          if (depth == 0) begin
            err = ST_UNDERFLOW;
          end else begin
            depth--;
            if (kinds[depth] != k) err = ST_MISMATCH;
          end
        end
      end
      if (eol) begin
        r.score = '0;
        if (err != ST_BALANCED) begin
          r.status = err;
        end else if (depth == 0) begin
          r.status = ST_BALANCED;
        end else begin
          r.status = ST_INCOMPLETE;
          for (int i = depth; i > 0; i--)
            r.score = r.score * 64'd5 + 64'(kinds[i-1]) + 64'd1;
        end
        lines_due = {lines_due, r};
        depth = 0;
        err   = ST_BALANCED;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [SCORE_W-1:0] sc);
      line_result_t r;
      results++;
      if (lines_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d score=%0h", $time, st, sc);
      end else begin
        r = lines_due.pop_front();
        if (st !== r.status) begin
          errors++;
          $display("%0t: line_status expected %0d actual %0d", $time, r.status, st);
        end
        if (sc !== r.score) begin
          errors++;
          $display("%0t: completion_score expected %0h actual %0h", $time, r.score, sc);
        end
      end
    endfunction

    function int pending();
      return lines_due.size();
    endfunction
  endclass

  logic                clk                  = 1'b0;
  logic                rst_n                = 1'b0;
  logic                in_valid             = 1'b0;
  logic                in_stall;
  logic [CHAR_W-1:0]   in_char_code         = '0;
  logic                in_end_of_line       = 1'b0;
  logic                out_valid;
  logic                out_stall            = 1'b0;
  logic [STATUS_W-1:0] out_line_status;
  logic [SCORE_W-1:0]  out_completion_score;

  nesting_scoreboard   sb = new();
  logic [CHAR_W-1:0]   line_buf [$];
  logic [CHAR_W-1:0]   open_ch  [4] = '{CH_OPEN_PAREN, CH_OPEN_SQUARE,
                                        CH_OPEN_CURLY, CH_OPEN_ANGLE};
  logic [CHAR_W-1:0]   close_ch [4] = '{CH_CLOSE_PAREN, CH_CLOSE_SQUARE,
                                        CH_CLOSE_CURLY, CH_CLOSE_ANGLE};
  bit                  quiet        = 1'b0;
  int                  items_sent   = 0;

  bracket_nesting_checker_top #(.STACK_DEPTH(DEPTH)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_char_code         (in_char_code),
    .in_end_of_line       (in_end_of_line),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_line_status      (out_line_status),
    .out_completion_score (out_completion_score)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    bit                hit;
    do begin
      c = CHAR_W'($urandom_range(0, 255));
      case (c)
        CH_OPEN_PAREN, CH_OPEN_SQUARE, CH_OPEN_CURLY, CH_OPEN_ANGLE,
        CH_CLOSE_PAREN, CH_CLOSE_SQUARE, CH_CLOSE_CURLY, CH_CLOSE_ANGLE: hit = 1'b1;
        default: hit = 1'b0;
      endcase
    end while (hit);
    return c;
  endfunction

  function automatic void add_char(input logic [CHAR_W-1:0] c);
    line_buf = {line_buf, c};
  endfunction

  function automatic logic [1:0] take_last(ref logic [1:0] q [$]);
    logic [1:0] v;
    v = q[q.size()-1];
    q.delete(q.size()-1);
    return v;
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic eol);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_code   <= c;
    in_end_of_line <= eol;
    do @(posedge clk); while (in_stall);
    sb.note_request(c, eol);
    items_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic send_str(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_line();
  endtask

  task automatic make_line(input int mode);
    int          len;
    int          r;
    int          n;
    logic [1:0]  k;
    logic [1:0]  opened [$];
    line_buf.delete();
    if (mode >= LM_OVERFLOW) begin
      n = (mode == LM_OVERFLOW) ? DEPTH + $urandom_range(1, 3) : DEPTH;
      for (int i = 0; i < n; i++) begin
        k = 2'($urandom_range(0, 3));
        add_char(open_ch[k]);
        opened = {opened, k};
      end
      if (mode == LM_OVERFLOW) begin
        add_char(close_ch[opened[opened.size()-1]]);
        add_char(plain_char());
      end else if (mode == LM_FULL_BALANCED) begin
        while (opened.size() > 0) add_char(close_ch[take_last(opened)]);
      end
    end else begin
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (mode == LM_NOISE) begin
          add_char(CHAR_W'($urandom_range(0, 255)));
        end else if (r < 20) begin
          add_char(plain_char());
        end else if (r < 60 && opened.size() < 40) begin
          k = 2'($urandom_range(0, 3));
          add_char(open_ch[k]);
          opened = {opened, k};
        end else if (mode == LM_BROKEN && r >= 92) begin
          add_char(close_ch[2'($urandom_range(0, 3))]);
          if (opened.size() > 0) void'(take_last(opened));
        end else if (opened.size() > 0) begin
          add_char(close_ch[take_last(opened)]);
        end else begin
          add_char(plain_char());
        end
      end
      if (mode == LM_BALANCED)
        while (opened.size() > 0) add_char(close_ch[take_last(opened)]);
      if (mode == LM_BROKEN && $urandom_range(0, 1))
        add_char(close_ch[2'($urandom_range(0, 3))]);
    end
    if (line_buf.size() == 0) add_char(plain_char());
  endtask

  initial begin : timeout
    repeat (LIMIT) @(posedge clk);
    $display("testbench failed");
    $finish;
  end

  initial begin : result_side
    int run;
    bit hold;
    int long_left;
    bit long_done;
    run       = 0;
    hold      = 1'b0;
    long_left = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall)
        sb.check_result(out_line_status, out_completion_score);
      // one long hold-off so results back up and the block stalls its input
      if (!long_done && sb.results >= 40) begin
        long_done = 1'b1;
        long_left = HOLD_LONG;
      end
      if (long_left > 0) begin
        long_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (run == 0) begin
          hold = ($urandom_range(0, 99) < 35);
          run  = hold ? idle_len() : $urandom_range(1, 8);
        end
        run--;
        out_stall <= hold;
      end
    end
  end

  initial begin : stimulus
    int line_no;
    int r;
    int deep_done;
    line_no   = 0;
    deep_done = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_str("()");
    send_str("([{<");
    send_str("]");
    send_str("(]x)");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_str("{}<>[]a");
    send_str(")(");
    send_str("{");

    while (items_sent < N_ITEMS) begin
      line_no++;
      if ($urandom_range(0, 7) == 0) quiet = !quiet;
      if (line_no % 20 == 10 && deep_done < 3) begin
        make_line(LM_OVERFLOW + deep_done);
        deep_done++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) make_line(LM_BALANCED);
        else if (r < 70) make_line(LM_OPEN);
        else if (r < 90) make_line(LM_BROKEN);
        else make_line(LM_NOISE);
      end
      send_line();
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
